[src/gca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gca_pkg;

  localparam int MAX_AGENTS = 16;
  localparam int AGENT_W    = 4;
  localparam int DATA_W     = 16;
  localparam int CAP_W      = 32;
  localparam int PROD_W     = 2 * DATA_W;
  // sum of two 16x16 products needs one extra bit
  localparam int SCORE_W    = PROD_W + 1;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DATA_W-1:0] WEIGHT_RESET = DATA_W'(256);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ENTRY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_COST     = 1'b0,
    CFG_WEIGHT_RESOURCE = 1'b1
  } cfg_idx_t;

  // write side of the agent table: capacity load and usage commit
  typedef struct packed {
    logic               load;
    logic [AGENT_W-1:0] load_agent;
    logic [CAP_W-1:0]   load_cap;
    logic               commit;
    logic [AGENT_W-1:0] commit_agent;
    logic [DATA_W-1:0]  commit_need;
  } tbl_wr_t;

endpackage

`default_nettype wire

[src/gca_score.sv]
`timescale 1ns / 1ps
`default_nettype none

module gca_score (
  input  wire logic [gca_pkg::DATA_W-1:0]  weight_cost,
  input  wire logic [gca_pkg::DATA_W-1:0]  weight_resource,
  input  wire logic [gca_pkg::DATA_W-1:0]  cost,
  input  wire logic [gca_pkg::DATA_W-1:0]  resource,
  output logic      [gca_pkg::SCORE_W-1:0] score
);

  logic [gca_pkg::PROD_W-1:0] cost_prod;
  logic [gca_pkg::PROD_W-1:0] res_prod;

  // Q8.8 * integer, kept exact as Q24.8; the sum is Q25.8
  always_comb begin
    cost_prod = weight_cost * cost;
    res_prod  = weight_resource * resource;
    score     = gca_pkg::SCORE_W'(cost_prod) + gca_pkg::SCORE_W'(res_prod);
  end

endmodule

`default_nettype wire

[src/gca_agent_tbl.sv]
`timescale 1ns / 1ps
`default_nettype none

module gca_agent_tbl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gca_pkg::tbl_wr_t              wr,
  input  wire logic [gca_pkg::AGENT_W-1:0]   rd_agent,
  output logic      [gca_pkg::CAP_W-1:0]     rd_cap,
  output logic      [gca_pkg::CAP_W-1:0]     rd_usage
);

  logic [gca_pkg::CAP_W-1:0] cap_r   [gca_pkg::MAX_AGENTS];
  logic [gca_pkg::CAP_W-1:0] usage_r [gca_pkg::MAX_AGENTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gca_pkg::MAX_AGENTS; i++) begin
        cap_r[i]   <= '0;
        usage_r[i] <= '0;
      end
    end else begin
      if (wr.load) begin
        cap_r[wr.load_agent]   <= wr.load_cap;
        usage_r[wr.load_agent] <= '0;
      end
      // fit test already bounds usage + need to the capacity
      if (wr.commit) begin
        usage_r[wr.commit_agent] <= usage_r[wr.commit_agent]
                                    + gca_pkg::CAP_W'(wr.commit_need);
      end
    end
  end

  assign rd_cap   = cap_r[rd_agent];
  assign rd_usage = usage_r[rd_agent];

endmodule

`default_nettype wire

[src/greedy_capacity_assignment_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Greedy job-to-agent assignment. Mode 0 beats load an agent's capacity and
// clear its usage; mode 1 beats present one agent's cost and resource need
// for the current job, and the unit keeps the lowest weighted score among
// agents where the job still fits (first one presented wins a tie). The beat
// marked last_agent commits the choice and produces one result beat;
// last_job also reports the instance outcome and clears the totals. Each
// beat passes through the single compute stage between the input and result
// registers, so one beat per cycle is sustained while in_stall is low;
// out_valid is registered and rises as the result-producing beat leaves the
// input register. While a result beat is held by out_stall, a following
// result-producing beat waits in the input register and in_stall is raised;
// loads and non-final entries keep flowing. The user must write weights
// through the cfg port only while idle; the unit does not enforce it.
module greedy_capacity_assignment_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            cfg_we,
  input  wire logic [gca_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [gca_pkg::DATA_W-1:0]      cfg_wdata,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_mode,
  input  wire logic [gca_pkg::AGENT_W-1:0]     in_agent,
  input  wire logic [gca_pkg::DATA_W-1:0]      in_cost,
  input  wire logic [gca_pkg::DATA_W-1:0]      in_resource,
  input  wire logic [gca_pkg::CAP_W-1:0]       in_capacity,
  input  wire logic                            in_last_agent,
  input  wire logic                            in_last_job,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_job_assigned,
  output logic      [gca_pkg::AGENT_W-1:0]     out_assigned_agent,
  output logic      [gca_pkg::CAP_W-1:0]       out_running_cost,
  output logic                                 out_instance_done,
  output logic                                 out_instance_ok,
  output logic      [gca_pkg::CAP_W-1:0]       out_final_cost
);

  // configuration
  logic [gca_pkg::DATA_W-1:0] weight_cost_r;
  logic [gca_pkg::DATA_W-1:0] weight_resource_r;

  // input register
  logic                          s1_valid_r;
  logic                          s1_mode_r;
  logic [gca_pkg::AGENT_W-1:0]   s1_agent_r;
  logic [gca_pkg::DATA_W-1:0]    s1_cost_r;
  logic [gca_pkg::DATA_W-1:0]    s1_res_r;
  logic [gca_pkg::CAP_W-1:0]     s1_cap_r;
  logic                          s1_last_agent_r;
  logic                          s1_last_job_r;

  // running minimum and totals
  logic                          best_found_r,  best_found_nxt;
  logic [gca_pkg::SCORE_W-1:0]   best_score_r,  best_score_nxt;
  logic [gca_pkg::AGENT_W-1:0]   best_agent_r,  best_agent_nxt;
  logic [gca_pkg::DATA_W-1:0]    best_cost_r,   best_cost_nxt;
  logic [gca_pkg::DATA_W-1:0]    best_need_r,   best_need_nxt;
  logic [gca_pkg::CAP_W-1:0]     total_cost_r,  total_cost_nxt;
  logic                          any_failed_r,  any_failed_nxt;

  // result register
  logic                          out_valid_r,   out_valid_nxt;
  logic                          res_assigned_r;
  logic [gca_pkg::AGENT_W-1:0]   res_agent_r;
  logic [gca_pkg::CAP_W-1:0]     res_running_r;
  logic                          res_done_r;
  logic                          res_ok_r;
  logic [gca_pkg::CAP_W-1:0]     res_final_r;

  logic                          out_free;
  logic                          s1_makes_res;
  logic                          s1_adv;
  logic                          entry_go;
  logic                          agent_ok;
  logic                          fits;
  logic                          take;
  logic [gca_pkg::SCORE_W-1:0]   score;
  logic [gca_pkg::CAP_W-1:0]     rd_cap;
  logic [gca_pkg::CAP_W-1:0]     rd_usage;
  logic [gca_pkg::CAP_W:0]       need_sum;
  logic [gca_pkg::CAP_W:0]       cost_sum;
  logic                          cand_found;
  logic [gca_pkg::AGENT_W-1:0]   cand_agent;
  logic [gca_pkg::DATA_W-1:0]    cand_cost;
  logic [gca_pkg::DATA_W-1:0]    cand_need;
  logic [gca_pkg::CAP_W-1:0]     total_new;
  logic                          failed_new;
  logic                          inst_ok;
  gca_pkg::tbl_wr_t              tbl_wr;

  gca_score u_score (
    .weight_cost     (weight_cost_r),
    .weight_resource (weight_resource_r),
    .cost            (s1_cost_r),
    .resource        (s1_res_r),
    .score           (score)
  );

  gca_agent_tbl u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd_agent (s1_agent_r),
    .rd_cap   (rd_cap),
    .rd_usage (rd_usage)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_cost_r     <= gca_pkg::WEIGHT_RESET;
      weight_resource_r <= gca_pkg::WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        gca_pkg::CFG_WEIGHT_COST:     weight_cost_r     <= cfg_wdata;
        gca_pkg::CFG_WEIGHT_RESOURCE: weight_resource_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: only result-producing beats wait on the output register
  always_comb begin
    out_free     = !out_valid_r || !out_stall;
    s1_makes_res = (s1_mode_r == gca_pkg::MODE_ENTRY) && s1_last_agent_r;
    s1_adv       = s1_valid_r && (!s1_makes_res || out_free);
    in_stall     = s1_valid_r && !s1_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_mode_r       <= in_mode;
      s1_agent_r      <= in_agent;
      s1_cost_r       <= in_cost;
      s1_res_r        <= in_resource;
      s1_cap_r        <= in_capacity;
      s1_last_agent_r <= in_last_agent;
      s1_last_job_r   <= in_last_job;
    end
  end

  always_comb begin
    agent_ok = 32'(s1_agent_r) < 32'(gca_pkg::MAX_AGENTS);
    entry_go = s1_adv && (s1_mode_r == gca_pkg::MODE_ENTRY);

    need_sum = {1'b0, rd_usage} + (gca_pkg::CAP_W + 1)'(s1_res_r);
    fits     = need_sum <= {1'b0, rd_cap};
    // strict compare keeps the earlier candidate on a tie
    take     = agent_ok && fits && (!best_found_r || (score < best_score_r));

    cand_found = take || best_found_r;
    cand_agent = take ? s1_agent_r : best_agent_r;
    cand_cost  = take ? s1_cost_r  : best_cost_r;
    cand_need  = take ? s1_res_r   : best_need_r;

    cost_sum   = {1'b0, total_cost_r} + (gca_pkg::CAP_W + 1)'(cand_cost);
    if (!cand_found) begin
      total_new = total_cost_r;
    end else if (cost_sum[gca_pkg::CAP_W]) begin
      total_new = '1;
    end else begin
      total_new = cost_sum[gca_pkg::CAP_W-1:0];
    end
    failed_new = any_failed_r || !cand_found;
    inst_ok    = s1_last_job_r && !failed_new;

    tbl_wr.load         = s1_adv && (s1_mode_r == gca_pkg::MODE_LOAD) && agent_ok;
    tbl_wr.load_agent   = s1_agent_r;
    tbl_wr.load_cap     = s1_cap_r;
    tbl_wr.commit       = entry_go && s1_last_agent_r && cand_found;
    tbl_wr.commit_agent = cand_agent;
    tbl_wr.commit_need  = cand_need;

    best_found_nxt = best_found_r;
    best_score_nxt = best_score_r;
    best_agent_nxt = best_agent_r;
    best_cost_nxt  = best_cost_r;
    best_need_nxt  = best_need_r;
    total_cost_nxt = total_cost_r;
    any_failed_nxt = any_failed_r;
    if (entry_go) begin
      if (!s1_last_agent_r) begin
        if (take) begin
          best_found_nxt = 1'b1;
          best_score_nxt = score;
          best_agent_nxt = s1_agent_r;
          best_cost_nxt  = s1_cost_r;
          best_need_nxt  = s1_res_r;
        end
      end else begin
        best_found_nxt = 1'b0;
        best_score_nxt = '0;
        best_agent_nxt = '0;
        best_cost_nxt  = '0;
        best_need_nxt  = '0;
        total_cost_nxt = s1_last_job_r ? '0   : total_new;
        any_failed_nxt = s1_last_job_r ? 1'b0 : failed_new;
      end
    end

    if (s1_adv && s1_makes_res) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      best_score_r <= '0;
      best_agent_r <= '0;
      best_cost_r  <= '0;
      best_need_r  <= '0;
      total_cost_r <= '0;
      any_failed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      best_found_r <= best_found_nxt;
      best_score_r <= best_score_nxt;
      best_agent_r <= best_agent_nxt;
      best_cost_r  <= best_cost_nxt;
      best_need_r  <= best_need_nxt;
      total_cost_r <= total_cost_nxt;
      any_failed_r <= any_failed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_makes_res) begin
      res_assigned_r <= cand_found;
      res_agent_r    <= cand_found ? cand_agent : '0;
      res_running_r  <= total_new;
      res_done_r     <= s1_last_job_r;
      res_ok_r       <= inst_ok;
      res_final_r    <= inst_ok ? total_new : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_job_assigned   = res_assigned_r;
  assign out_assigned_agent = res_agent_r;
  assign out_running_cost   = res_running_r;
  assign out_instance_done  = res_done_r;
  assign out_instance_ok    = res_ok_r;
  assign out_final_cost     = res_final_r;

endmodule

`default_nettype wire

[src/gca_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module gca_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            out_job_assigned,
  input wire logic [gca_pkg::AGENT_W-1:0]     out_assigned_agent,
  input wire logic [gca_pkg::CAP_W-1:0]       out_running_cost,
  input wire logic                            out_instance_done,
  input wire logic                            out_instance_ok,
  input wire logic [gca_pkg::CAP_W-1:0]       out_final_cost
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_running_cost)
                               && $stable(out_assigned_agent))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("unit not idle after reset");

  a_ok_implies: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_instance_ok |->
      out_instance_done && out_job_assigned && (out_final_cost == out_running_cost))
    else $error("instance success without a completed assignment");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_instance_ok |-> out_final_cost == '0)
    else $error("final cost nonzero without instance success");

  a_unassigned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_job_assigned |-> out_assigned_agent == '0)
    else $error("agent index reported for an unassigned job");

endmodule

bind greedy_capacity_assignment_unit gca_checker u_gca_checker (.*);

`default_nettype wire
